[rtl/kvcl_pkg.sv]
`default_nettype none

package kvcl_pkg;

    // sizes
    localparam int MAX_TOKEN_LEN_DEF = 64;
    localparam int LIMIT_W           = 7;
    localparam int LINE_W            = 16;
    localparam int CMDQ_DEPTH        = 2;
    localparam int OUTQ_DEPTH        = 4;

    localparam logic [LIMIT_W-1:0] LIMIT_RESET = 7'd64;

    // special characters
    localparam logic [7:0] CH_HASH  = 8'h23;
    localparam logic [7:0] CH_QUOTE = 8'h22;
    localparam logic [7:0] CH_EQ    = 8'h3D;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_SPACE = 8'h20;

    typedef enum logic [1:0] {
        REQ_TEXT    = 2'd0,
        REQ_END     = 2'd1,
        REQ_RESTART = 2'd2
    } req_t;

    typedef struct packed {
        logic space_tab;
        logic newline;
        logic hash;
        logic equals;
        logic quote;
        logic ctrl;
    } char_class_t;

    typedef struct packed {
        req_t        req;
        logic [7:0]  ch;
        char_class_t cls;
    } cmd_t;

    typedef enum logic [3:0] {
        PH_KEY_WAIT   = 4'd0,
        PH_KEY_PLAIN  = 4'd1,
        PH_KEY_QUOTED = 4'd2,
        PH_EQ_WAIT    = 4'd3,
        PH_EQ_QUOTED  = 4'd4,
        PH_VAL_WAIT   = 4'd5,
        PH_VAL_PLAIN  = 4'd6,
        PH_VAL_QUOTED = 4'd7,
        PH_COMMENT    = 4'd8,
        PH_HALTED     = 4'd9
    } phase_t;

    typedef enum logic [1:0] {
        WH_KEY = 2'd0,
        WH_EQ  = 2'd1,
        WH_VAL = 2'd2
    } which_t;

    typedef enum logic [1:0] {
        EQC_EMPTY  = 2'd0,
        EQC_EQUALS = 2'd1,
        EQC_OTHER  = 2'd2
    } eqc_t;

    typedef enum logic [2:0] {
        EV_KEY  = 3'd0,
        EV_VAL  = 3'd1,
        EV_PAIR = 3'd2,
        EV_END  = 3'd3,
        EV_ERR  = 3'd4
    } event_t;

    typedef enum logic [2:0] {
        ERR_NONE        = 3'd0,
        ERR_KEY_EQ      = 3'd1,
        ERR_EQ_EXPECTED = 3'd2,
        ERR_VAL_MISSING = 3'd3,
        ERR_VAL_EQ      = 3'd4,
        ERR_TOO_LONG    = 3'd5,
        ERR_END_QUOTE   = 3'd6
    } err_t;

    typedef struct packed {
        event_t            ev;
        logic [7:0]        ch;
        err_t              err;
        logic              warn;
        logic [LINE_W-1:0] line;
    } result_t;

endpackage

`default_nettype wire

[rtl/kvcl_if.sv]
`default_nettype none

// input channel: request type and text byte
interface kvcl_in_if;
    import kvcl_pkg::*;

    logic       valid;
    logic       ready;
    logic [1:0] req_type;
    logic [7:0] in_byte;

    modport source (output valid, output req_type, output in_byte, input ready);
    modport sink   (input valid, input req_type, input in_byte, output ready);
endinterface

// output channel: one lexer event per item
interface kvcl_out_if;
    import kvcl_pkg::*;

    logic              valid;
    logic              ready;
    logic [2:0]        event_res;
    logic [7:0]        out_byte;
    logic [2:0]        error_code;
    logic              bad_char_warning;
    logic [LINE_W-1:0] line_number;

    modport source (output valid, output event_res, output out_byte, output error_code,
                    output bad_char_warning, output line_number, input ready);
    modport sink   (input valid, input event_res, input out_byte, input error_code,
                    input bad_char_warning, input line_number, output ready);
endinterface

`default_nettype wire

[rtl/kvcl_front.sv]
`default_nettype none

module kvcl_front (
    input  wire logic          clk,
    input  wire logic          rst_n,
    kvcl_in_if.sink            in_ch,
    output kvcl_pkg::cmd_t     cmd,
    output logic               cmd_valid,
    input  wire logic          cmd_ready
);
    import kvcl_pkg::*;

    logic        valid_reg;
    logic        valid_next;
    cmd_t        cmd_reg;
    cmd_t        cmd_next;
    logic        take;
    logic        known;

    // stage is free when empty or when its item moves on
    assign in_ch.ready = !valid_reg || cmd_ready;
    assign take        = in_ch.valid && in_ch.ready;

    // decode request and classify the byte
    always_comb
    begin
        known         = 1'b1;
        cmd_next.req  = REQ_TEXT;
        unique case (in_ch.req_type)
            REQ_TEXT:    cmd_next.req = REQ_TEXT;
            REQ_END:     cmd_next.req = REQ_END;
            REQ_RESTART: cmd_next.req = REQ_RESTART;
            default:     known = 1'b0;
        endcase
        cmd_next.ch            = in_ch.in_byte;
        cmd_next.cls.space_tab = (in_ch.in_byte == CH_SPACE) || (in_ch.in_byte == CH_TAB);
        cmd_next.cls.newline   = (in_ch.in_byte == CH_LF) || (in_ch.in_byte == CH_CR);
        cmd_next.cls.hash      = (in_ch.in_byte == CH_HASH);
        cmd_next.cls.equals    = (in_ch.in_byte == CH_EQ);
        cmd_next.cls.quote     = (in_ch.in_byte == CH_QUOTE);
        cmd_next.cls.ctrl      = (in_ch.in_byte == CH_TAB) || (in_ch.in_byte == CH_LF)
                                 || (in_ch.in_byte == CH_CR);
    end

    // unused request codes are dropped here
    assign valid_next = take && known;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ch.ready)
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            cmd_reg <= cmd_next;
        end
    end

    assign cmd       = cmd_reg;
    assign cmd_valid = valid_reg;

endmodule

`default_nettype wire

[rtl/kvcl_fifo.sv]
`default_nettype none

module kvcl_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             push_valid,
    output logic                  push_ready,
    input  wire logic [WIDTH-1:0] push_data,
    output logic                  pop_valid,
    input  wire logic             pop_ready,
    output logic [WIDTH-1:0]      pop_data
);
    import kvcl_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             push;
    logic             pop;

    assign push_ready = (count_reg != CNT_W'(DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign push       = push_valid && push_ready;
    assign pop        = pop_valid && pop_ready;
    assign pop_data   = mem[rd_ptr_reg];

    // pointer wrap and occupancy
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= push_data;
        end
    end

endmodule

`default_nettype wire

[rtl/kvcl_parser.sv]
`default_nettype none

module kvcl_parser #(
    parameter int MAX_TOKEN_LEN = kvcl_pkg::MAX_TOKEN_LEN_DEF
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic [kvcl_pkg::LIMIT_W-1:0] token_limit,
    input  wire kvcl_pkg::cmd_t               cmd,
    input  wire logic                         cmd_valid,
    output logic                              cmd_ready,
    input  wire logic [$clog2(kvcl_pkg::OUTQ_DEPTH+1)-1:0] space,
    output logic [1:0]                        push_cnt,
    output kvcl_pkg::result_t                 push_res [2]
);
    import kvcl_pkg::*;

    localparam int TL_W  = $clog2(MAX_TOKEN_LEN + 1);
    localparam int CMP_W = (TL_W > LIMIT_W) ? TL_W : LIMIT_W;
    localparam int SP_W  = $clog2(OUTQ_DEPTH + 1);

    // what one item emits, in output order: pair, char, end, error
    typedef struct packed {
        logic   pair;
        logic   chr;
        event_t chr_ev;
        logic   warn;
        logic   fin;
        logic   err_en;
        err_t   err;
    } plan_t;

    phase_t            phase_reg;
    phase_t            phase_next;
    which_t            resume_reg;
    which_t            resume_next;
    logic [TL_W-1:0]   len_reg;
    logic [TL_W-1:0]   len_next;
    eqc_t              eqc_reg;
    eqc_t              eqc_next;
    logic [LINE_W-1:0] line_reg;
    logic [LINE_W-1:0] line_next;
    logic [LINE_W-1:0] line_inc;

    plan_t             plan;
    logic              do_wait;
    which_t            wwhich;
    logic              do_quoted;
    which_t            qwhich;
    logic [CMP_W-1:0]  lim_ext;
    logic [CMP_W-1:0]  eff_limit;
    logic              at_limit;
    logic [1:0]        cnt;
    logic              fire;

    // effective limit: zero acts as one, capped at the maximum
    always_comb
    begin
        lim_ext   = CMP_W'(token_limit);
        eff_limit = lim_ext;
        if (lim_ext == '0)
        begin
            eff_limit = CMP_W'(1);
        end
        else if (lim_ext > CMP_W'(MAX_TOKEN_LEN))
        begin
            eff_limit = CMP_W'(MAX_TOKEN_LEN);
        end
    end

    assign at_limit = (CMP_W'(len_reg) >= eff_limit);
    assign line_inc = (line_reg == '1) ? line_reg : line_reg + 1'b1;

    // next state and emit plan
    always_comb
    begin
        phase_next  = phase_reg;
        resume_next = resume_reg;
        len_next    = len_reg;
        eqc_next    = eqc_reg;
        line_next   = line_reg;
        plan        = '0;
        plan.chr_ev = EV_KEY;
        plan.err    = ERR_NONE;
        do_wait     = 1'b0;
        wwhich      = WH_KEY;
        do_quoted   = 1'b0;
        qwhich      = WH_KEY;

        unique case (cmd.req)
            REQ_RESTART:
            begin
                phase_next  = PH_KEY_WAIT;
                resume_next = WH_KEY;
                len_next    = '0;
                eqc_next    = EQC_EMPTY;
                line_next   = LINE_W'(1);
            end
            REQ_END:
            begin
                unique case (phase_reg)
                    PH_KEY_WAIT:
                    begin
                        plan.fin   = 1'b1;
                        phase_next = PH_HALTED;
                    end
                    PH_KEY_PLAIN, PH_EQ_WAIT:
                    begin
                        plan.err_en = 1'b1;
                        plan.err    = ERR_EQ_EXPECTED;
                        phase_next  = PH_HALTED;
                    end
                    PH_VAL_WAIT:
                    begin
                        plan.err_en = 1'b1;
                        plan.err    = ERR_VAL_MISSING;
                        phase_next  = PH_HALTED;
                    end
                    PH_KEY_QUOTED, PH_EQ_QUOTED, PH_VAL_QUOTED:
                    begin
                        plan.err_en = 1'b1;
                        plan.err    = ERR_END_QUOTE;
                        phase_next  = PH_HALTED;
                    end
                    PH_VAL_PLAIN:
                    begin
                        plan.pair  = 1'b1;
                        plan.fin   = 1'b1;
                        phase_next = PH_HALTED;
                    end
                    PH_COMMENT:
                    begin
                        phase_next = PH_HALTED;
                        priority if (resume_reg == WH_KEY)
                        begin
                            plan.fin = 1'b1;
                        end
                        else if (resume_reg == WH_EQ)
                        begin
                            plan.err_en = 1'b1;
                            plan.err    = ERR_EQ_EXPECTED;
                        end
                        else
                        begin
                            plan.err_en = 1'b1;
                            plan.err    = ERR_VAL_MISSING;
                        end
                    end
                    default: ;
                endcase
            end
            default:
            begin
                unique case (phase_reg)
                    PH_KEY_WAIT:
                    begin
                        do_wait = 1'b1;
                        wwhich  = WH_KEY;
                    end
                    PH_EQ_WAIT:
                    begin
                        do_wait = 1'b1;
                        wwhich  = WH_EQ;
                    end
                    PH_VAL_WAIT:
                    begin
                        do_wait = 1'b1;
                        wwhich  = WH_VAL;
                    end
                    PH_KEY_PLAIN, PH_VAL_PLAIN:
                    begin
                        if (cmd.cls.space_tab || cmd.cls.newline || cmd.cls.hash
                            || cmd.cls.equals)
                        begin
                            // the delimiter is then handled as a char seen while waiting
                            do_wait = 1'b1;
                            if (phase_reg == PH_KEY_PLAIN)
                            begin
                                wwhich     = WH_EQ;
                                phase_next = PH_EQ_WAIT;
                            end
                            else
                            begin
                                plan.pair  = 1'b1;
                                wwhich     = WH_KEY;
                                phase_next = PH_KEY_WAIT;
                            end
                        end
                        else if (at_limit)
                        begin
                            plan.err_en = 1'b1;
                            plan.err    = ERR_TOO_LONG;
                            phase_next  = PH_HALTED;
                        end
                        else
                        begin
                            len_next    = len_reg + 1'b1;
                            plan.chr    = 1'b1;
                            plan.chr_ev = (phase_reg == PH_KEY_PLAIN) ? EV_KEY : EV_VAL;
                        end
                    end
                    PH_KEY_QUOTED:
                    begin
                        do_quoted = 1'b1;
                        qwhich    = WH_KEY;
                    end
                    PH_EQ_QUOTED:
                    begin
                        do_quoted = 1'b1;
                        qwhich    = WH_EQ;
                    end
                    PH_VAL_QUOTED:
                    begin
                        do_quoted = 1'b1;
                        qwhich    = WH_VAL;
                    end
                    PH_COMMENT:
                    begin
                        if (cmd.cls.newline)
                        begin
                            line_next = line_inc;
                            unique case (resume_reg)
                                WH_KEY:  phase_next = PH_KEY_WAIT;
                                WH_EQ:   phase_next = PH_EQ_WAIT;
                                default: phase_next = PH_VAL_WAIT;
                            endcase
                        end
                    end
                    default: ;
                endcase
            end
        endcase

        // char seen while waiting for a token
        if (do_wait)
        begin
            priority if (cmd.cls.space_tab)
            begin
                // skipped
            end
            else if (cmd.cls.newline)
            begin
                line_next = line_inc;
            end
            else if (cmd.cls.hash)
            begin
                resume_next = wwhich;
                phase_next  = PH_COMMENT;
            end
            else if (cmd.cls.equals)
            begin
                priority if (wwhich == WH_EQ)
                begin
                    phase_next = PH_VAL_WAIT;
                end
                else
                begin
                    plan.err_en = 1'b1;
                    plan.err    = (wwhich == WH_KEY) ? ERR_KEY_EQ : ERR_VAL_EQ;
                    phase_next  = PH_HALTED;
                end
            end
            else if (cmd.cls.quote)
            begin
                len_next = '0;
                eqc_next = EQC_EMPTY;
                unique case (wwhich)
                    WH_KEY:  phase_next = PH_KEY_QUOTED;
                    WH_EQ:   phase_next = PH_EQ_QUOTED;
                    default: phase_next = PH_VAL_QUOTED;
                endcase
            end
            else if (wwhich == WH_EQ)
            begin
                plan.err_en = 1'b1;
                plan.err    = ERR_EQ_EXPECTED;
                phase_next  = PH_HALTED;
            end
            else
            begin
                len_next    = TL_W'(1);
                plan.chr    = 1'b1;
                plan.chr_ev = (wwhich == WH_KEY) ? EV_KEY : EV_VAL;
                phase_next  = (wwhich == WH_KEY) ? PH_KEY_PLAIN : PH_VAL_PLAIN;
            end
        end

        // char seen inside quotes
        if (do_quoted)
        begin
            if (cmd.cls.quote)
            begin
                unique case (qwhich)
                    WH_KEY:
                    begin
                        if (eqc_reg == EQC_EQUALS)
                        begin
                            plan.err_en = 1'b1;
                            plan.err    = ERR_KEY_EQ;
                            phase_next  = PH_HALTED;
                        end
                        else
                        begin
                            phase_next = PH_EQ_WAIT;
                        end
                    end
                    WH_EQ:
                    begin
                        if (eqc_reg == EQC_EQUALS)
                        begin
                            phase_next = PH_VAL_WAIT;
                        end
                        else
                        begin
                            plan.err_en = 1'b1;
                            plan.err    = ERR_EQ_EXPECTED;
                            phase_next  = PH_HALTED;
                        end
                    end
                    default:
                    begin
                        if (eqc_reg == EQC_EQUALS)
                        begin
                            plan.err_en = 1'b1;
                            plan.err    = ERR_VAL_EQ;
                            phase_next  = PH_HALTED;
                        end
                        else
                        begin
                            plan.pair  = 1'b1;
                            phase_next = PH_KEY_WAIT;
                        end
                    end
                endcase
            end
            else if (at_limit)
            begin
                plan.err_en = 1'b1;
                plan.err    = ERR_TOO_LONG;
                phase_next  = PH_HALTED;
            end
            else
            begin
                eqc_next    = ((len_reg == '0) && cmd.cls.equals) ? EQC_EQUALS : EQC_OTHER;
                len_next    = len_reg + 1'b1;
                plan.chr    = (qwhich != WH_EQ);
                plan.chr_ev = (qwhich == WH_KEY) ? EV_KEY : EV_VAL;
                plan.warn   = cmd.cls.ctrl;
            end
        end
    end

    // result items from the plan, packed in order
    always_comb
    begin
        push_res[0] = '0;
        push_res[1] = '0;
        cnt         = '0;
        if (plan.pair)
        begin
            push_res[cnt[0]] = '{ev: EV_PAIR, ch: 8'd0, err: ERR_NONE, warn: 1'b0,
                                 line: line_reg};
            cnt = cnt + 1'b1;
        end
        if (plan.chr)
        begin
            push_res[cnt[0]] = '{ev: plan.chr_ev, ch: cmd.ch, err: ERR_NONE,
                                 warn: plan.warn, line: line_reg};
            cnt = cnt + 1'b1;
        end
        if (plan.fin)
        begin
            push_res[cnt[0]] = '{ev: EV_END, ch: 8'd0, err: ERR_NONE, warn: 1'b0,
                                 line: line_reg};
            cnt = cnt + 1'b1;
        end
        if (plan.err_en)
        begin
            push_res[cnt[0]] = '{ev: EV_ERR, ch: 8'd0, err: plan.err, warn: 1'b0,
                                 line: line_reg};
            cnt = cnt + 1'b1;
        end
    end

    // take the item only when all its results fit
    assign cmd_ready = (SP_W'(cnt) <= space);
    assign fire      = cmd_valid && cmd_ready;
    assign push_cnt  = fire ? cnt : 2'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_KEY_WAIT;
            resume_reg <= WH_KEY;
            len_reg    <= '0;
            eqc_reg    <= EQC_EMPTY;
            line_reg   <= LINE_W'(1);
        end
        else if (fire)
        begin
            phase_reg  <= phase_next;
            resume_reg <= resume_next;
            len_reg    <= len_next;
            eqc_reg    <= eqc_next;
            line_reg   <= line_next;
        end
    end

endmodule

`default_nettype wire

[rtl/kvcl_outq.sv]
`default_nettype none

module kvcl_outq (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic [1:0]        push_cnt,
    input  wire kvcl_pkg::result_t push_res [2],
    output logic [$clog2(kvcl_pkg::OUTQ_DEPTH+1)-1:0] space,
    kvcl_out_if.source             out_ch
);
    import kvcl_pkg::*;

    localparam int PTR_W = $clog2(OUTQ_DEPTH);
    localparam int CNT_W = $clog2(OUTQ_DEPTH + 1);

    result_t          mem [OUTQ_DEPTH];
    result_t          head;
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             pop;

    assign pop   = out_ch.valid && out_ch.ready;
    assign space = CNT_W'(OUTQ_DEPTH) - count_reg;

    // occupancy with up to two pushes and one pop a cycle
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg + PTR_W'(push_cnt);
        rd_ptr_next = rd_ptr_reg + PTR_W'(pop);
        count_next  = count_reg + CNT_W'(push_cnt) - CNT_W'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push_cnt != 2'd0)
        begin
            mem[wr_ptr_reg] <= push_res[0];
        end
        if (push_cnt == 2'd2)
        begin
            mem[wr_ptr_reg + 1'b1] <= push_res[1];
        end
    end

    // head entry drives the channel
    assign head                    = mem[rd_ptr_reg];
    assign out_ch.valid            = (count_reg != '0);
    assign out_ch.event_res        = head.ev;
    assign out_ch.out_byte         = head.ch;
    assign out_ch.error_code       = head.err;
    assign out_ch.bad_char_warning = head.warn;
    assign out_ch.line_number      = head.line;

endmodule

`default_nettype wire

[rtl/key_value_config_lexer.sv]
// Streaming lexer for "key = value" text, one byte per input item. The front stage
// registers and classifies each item and hands it through a two-entry command queue to
// the parser, which updates the parse state and writes zero, one or two events into a
// four-entry output queue. The block takes one item per cycle as long as the output side
// keeps up. The output queue drains one event per cycle while out_ch.ready is high, so
// items that emit two events (pair complete followed by clean end or by an error) drain
// more slowly, and the parser holds an item until the output queue has room for all of
// its events. token_limit may be written only while the block holds no pending item.
`default_nettype none

module key_value_config_lexer #(
    parameter int MAX_TOKEN_LEN = kvcl_pkg::MAX_TOKEN_LEN_DEF
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         cfg_wr_en,
    input  wire logic [kvcl_pkg::LIMIT_W-1:0] cfg_wr_data,
    kvcl_in_if.sink                           in_ch,
    kvcl_out_if.source                        out_ch
);
    import kvcl_pkg::*;

    localparam int CMD_W = $bits(cmd_t);
    localparam int SP_W  = $clog2(OUTQ_DEPTH + 1);

    logic [LIMIT_W-1:0] limit_reg;
    cmd_t               fr_cmd;
    logic               fr_valid;
    logic               fr_ready;
    logic [CMD_W-1:0]   q_data;
    logic               q_valid;
    logic               q_ready;
    cmd_t               q_cmd;
    logic [SP_W-1:0]    oq_space;
    logic [1:0]         push_cnt;
    result_t            push_res [2];

    // token length limit register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            limit_reg <= LIMIT_RESET;
        end
        else if (cfg_wr_en)
        begin
            limit_reg <= cfg_wr_data;
        end
    end

    // accept and classify
    kvcl_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_ch     (in_ch),
        .cmd       (fr_cmd),
        .cmd_valid (fr_valid),
        .cmd_ready (fr_ready)
    );

    // command queue between front and parser
    kvcl_fifo #(
        .WIDTH (CMD_W),
        .DEPTH (CMDQ_DEPTH)
    ) u_cmdq (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (fr_valid),
        .push_ready (fr_ready),
        .push_data  (fr_cmd),
        .pop_valid  (q_valid),
        .pop_ready  (q_ready),
        .pop_data   (q_data)
    );

    assign q_cmd = cmd_t'(q_data);

    // parse state machine
    kvcl_parser #(
        .MAX_TOKEN_LEN (MAX_TOKEN_LEN)
    ) u_parser (
        .clk         (clk),
        .rst_n       (rst_n),
        .token_limit (limit_reg),
        .cmd         (q_cmd),
        .cmd_valid   (q_valid),
        .cmd_ready   (q_ready),
        .space       (oq_space),
        .push_cnt    (push_cnt),
        .push_res    (push_res)
    );

    // output event queue
    kvcl_outq u_outq (
        .clk      (clk),
        .rst_n    (rst_n),
        .push_cnt (push_cnt),
        .push_res (push_res),
        .space    (oq_space),
        .out_ch   (out_ch)
    );

endmodule

`default_nettype wire

[tb/sv/key_value_config_lexer_tb.sv]
`timescale 1ns / 100ps

module key_value_config_lexer_tb;
    import kvcl_pkg::*;

    localparam logic [1:0] REQ_UNUSED  = 2'd3;
    localparam int         CYCLE_LIMIT = 100000;
    localparam int         BLOCK_ITEMS = 180;
    localparam int         SETTLE_CYC  = 8;

    // one stimulus item: request type and text byte
    typedef struct packed {
        logic [1:0] req;
        logic [7:0] ch;
    } stim_t;

    // expected lexer events and the parse state that produces them
    class lexer_event_board;
        result_t     pending_events[$];
        int          bad_events;
        int          parsed_items;
        logic [6:0]  limit_reg;
        phase_t      phase;
        which_t      resume;
        int          tok_len;
        eqc_t        eqc;
        logic [15:0] line_cnt;

        function new();
            bad_events   = 0;
            parsed_items = 0;
            limit_reg    = LIMIT_RESET;
            restart_parse();
        endfunction

        function void restart_parse();
            phase    = PH_KEY_WAIT;
            resume   = WH_KEY;
            tok_len  = 0;
            eqc      = EQC_EMPTY;
            line_cnt = 16'd1;
        endfunction

        function void write_limit(logic [6:0] v);
            limit_reg = v;
        endfunction

        function int effective_limit();
            if (limit_reg == 0)
                return 1;
            if (limit_reg > MAX_TOKEN_LEN_DEF)
                return MAX_TOKEN_LEN_DEF;
            return limit_reg;
        endfunction

        function void push_event(event_t ev, logic [7:0] c, err_t code, logic warn);
            result_t r;
            r.ev   = ev;
            r.ch   = c;
            r.err  = code;
            r.warn = warn;
            r.line = line_cnt;
            pending_events.push_back(r);
        endfunction

        function void halt_with(err_t code);
            push_event(EV_ERR, 8'h00, code, 1'b0);
            phase = PH_HALTED;
        endfunction

        function void bump_line();
            if (line_cnt != 16'hFFFF)
                line_cnt++;
        endfunction

        // char seen while waiting for a key, an equals sign or a value
        function void wait_char(which_t which, logic [7:0] c);
            if (c == CH_SPACE || c == CH_TAB)
                return;
            if (c == CH_LF || c == CH_CR)
            begin
                bump_line();
                return;
            end
            if (c == CH_HASH)
            begin
                resume = which;
                phase  = PH_COMMENT;
                return;
            end
            if (c == CH_EQ)
            begin
                case (which)
                    WH_KEY:  halt_with(ERR_KEY_EQ);
                    WH_EQ:   phase = PH_VAL_WAIT;
                    default: halt_with(ERR_VAL_EQ);
                endcase
                return;
            end
            if (c == CH_QUOTE)
            begin
                tok_len = 0;
                eqc     = EQC_EMPTY;
                case (which)
                    WH_KEY:  phase = PH_KEY_QUOTED;
                    WH_EQ:   phase = PH_EQ_QUOTED;
                    default: phase = PH_VAL_QUOTED;
                endcase
                return;
            end
            if (which == WH_EQ)
            begin
                halt_with(ERR_EQ_EXPECTED);
                return;
            end
            tok_len = 1;
            if (which == WH_KEY)
            begin
                phase = PH_KEY_PLAIN;
                push_event(EV_KEY, c, ERR_NONE, 1'b0);
            end
            else
            begin
                phase = PH_VAL_PLAIN;
                push_event(EV_VAL, c, ERR_NONE, 1'b0);
            end
        endfunction

        // char inside an unquoted key or value; a delimiter ends the token
        function void plain_char(bit is_key, logic [7:0] c);
            if (c == CH_SPACE || c == CH_TAB || c == CH_LF || c == CH_CR ||
                c == CH_HASH || c == CH_EQ)
            begin
                if (is_key)
                begin
                    phase = PH_EQ_WAIT;
                    wait_char(WH_EQ, c);
                end
                else
                begin
                    push_event(EV_PAIR, 8'h00, ERR_NONE, 1'b0);
                    phase = PH_KEY_WAIT;
                    wait_char(WH_KEY, c);
                end
                return;
            end
            if (tok_len >= effective_limit())
            begin
                halt_with(ERR_TOO_LONG);
                return;
            end
            tok_len++;
            if (is_key)
                push_event(EV_KEY, c, ERR_NONE, 1'b0);
            else
                push_event(EV_VAL, c, ERR_NONE, 1'b0);
        endfunction

        // char inside quotes; a lone '=' as content stands for the equals sign
        function void quoted_char(which_t which, logic [7:0] c);
            bit   is_eq;
            logic warn;
            if (c == CH_QUOTE)
            begin
                is_eq = (eqc == EQC_EQUALS);
                case (which)
                    WH_KEY:
                    begin
                        if (is_eq) halt_with(ERR_KEY_EQ);
                        else phase = PH_EQ_WAIT;
                    end
                    WH_EQ:
                    begin
                        if (is_eq) phase = PH_VAL_WAIT;
                        else halt_with(ERR_EQ_EXPECTED);
                    end
                    default:
                    begin
                        if (is_eq)
                            halt_with(ERR_VAL_EQ);
                        else
                        begin
                            push_event(EV_PAIR, 8'h00, ERR_NONE, 1'b0);
                            phase = PH_KEY_WAIT;
                        end
                    end
                endcase
                return;
            end
            if (tok_len >= effective_limit())
            begin
                halt_with(ERR_TOO_LONG);
                return;
            end
            if (tok_len == 0 && c == CH_EQ)
                eqc = EQC_EQUALS;
            else
                eqc = EQC_OTHER;
            tok_len++;
            warn = (c == CH_TAB || c == CH_LF || c == CH_CR);
            if (which == WH_KEY)
                push_event(EV_KEY, c, ERR_NONE, warn);
            else if (which == WH_VAL)
                push_event(EV_VAL, c, ERR_NONE, warn);
        endfunction

        function void text_byte(logic [7:0] c);
            case (phase)
                PH_KEY_WAIT:   wait_char(WH_KEY, c);
                PH_KEY_PLAIN:  plain_char(1'b1, c);
                PH_KEY_QUOTED: quoted_char(WH_KEY, c);
                PH_EQ_WAIT:    wait_char(WH_EQ, c);
                PH_EQ_QUOTED:  quoted_char(WH_EQ, c);
                PH_VAL_WAIT:   wait_char(WH_VAL, c);
                PH_VAL_PLAIN:  plain_char(1'b0, c);
                PH_VAL_QUOTED: quoted_char(WH_VAL, c);
                PH_COMMENT:
                begin
                    if (c == CH_LF || c == CH_CR)
                    begin
                        bump_line();
                        if (resume == WH_KEY)
                            phase = PH_KEY_WAIT;
                        else if (resume == WH_EQ)
                            phase = PH_EQ_WAIT;
                        else
                            phase = PH_VAL_WAIT;
                    end
                end
                default: ;
            endcase
        endfunction

        function void end_input();
            case (phase)
                PH_KEY_WAIT:
                begin
                    push_event(EV_END, 8'h00, ERR_NONE, 1'b0);
                    phase = PH_HALTED;
                end
                PH_KEY_PLAIN, PH_EQ_WAIT: halt_with(ERR_EQ_EXPECTED);
                PH_VAL_WAIT: halt_with(ERR_VAL_MISSING);
                PH_KEY_QUOTED, PH_EQ_QUOTED, PH_VAL_QUOTED: halt_with(ERR_END_QUOTE);
                PH_VAL_PLAIN:
                begin
                    push_event(EV_PAIR, 8'h00, ERR_NONE, 1'b0);
                    push_event(EV_END, 8'h00, ERR_NONE, 1'b0);
                    phase = PH_HALTED;
                end
                PH_COMMENT:
                begin
                    if (resume == WH_KEY)
                    begin
                        push_event(EV_END, 8'h00, ERR_NONE, 1'b0);
                        phase = PH_HALTED;
                    end
                    else if (resume == WH_EQ)
                        halt_with(ERR_EQ_EXPECTED);
                    else
                        halt_with(ERR_VAL_MISSING);
                end
                default: ;
            endcase
        endfunction

        // accepted input item: advance the parse state, queue its events
        function void note_item(logic [1:0] req, logic [7:0] c);
            if ((req == REQ_TEXT || req == REQ_END) && phase != PH_HALTED)
                parsed_items++;
            if (req == REQ_TEXT)
                text_byte(c);
            else if (req == REQ_END)
                end_input();
            else if (req == REQ_RESTART)
                restart_parse();
        endfunction

        function void compare_field(string name, logic [15:0] want, logic [15:0] got);
            if (got !== want)
            begin
                $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
                bad_events++;
            end
        endfunction

        // delivered event against the oldest expectation
        function void check_result(result_t got);
            result_t want;
            if (pending_events.size() == 0)
            begin
                $display("%0t: unexpected event, expected none, actual ev %0d ch %02h err %0d",
                         $time, got.ev, got.ch, got.err);
                bad_events++;
                return;
            end
            want = pending_events.pop_front();
            compare_field("event_res", 16'(want.ev), 16'(got.ev));
            compare_field("out_byte", 16'(want.ch), 16'(got.ch));
            compare_field("error_code", 16'(want.err), 16'(got.err));
            compare_field("bad_char_warning", 16'(want.warn), 16'(got.warn));
            compare_field("line_number", want.line, got.line);
        endfunction
    endclass

    logic       clk;
    logic       rst_n;
    logic       cfg_wr_en;
    logic [6:0] cfg_wr_data;
    int         gap_pct;
    int         stall_pct;
    int         cycle_count;
    stim_t      line_q[$];
    string      word_chars = "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ0123456789_.-";

    lexer_event_board sb;

    kvcl_in_if  in_ch ();
    kvcl_out_if out_ch ();

    key_value_config_lexer dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .in_ch       (in_ch),
        .out_ch      (out_ch)
    );

    // clock
    always #5 clk = ~clk;

    // run time guard
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("key_value_config_lexer test failed");
            $finish;
        end
    end

    // output backpressure
    always @(negedge clk)
        out_ch.ready = ($urandom_range(0, 99) >= stall_pct);

    // check every delivered event
    always @(posedge clk)
    begin
        if (rst_n && out_ch.valid && out_ch.ready)
            sb.check_result(result_t'({out_ch.event_res, out_ch.out_byte, out_ch.error_code,
                                       out_ch.bad_char_warning, out_ch.line_number}));
    end

    // drive one item and wait for its acceptance
    task automatic send_item(logic [1:0] req, logic [7:0] c);
        @(negedge clk);
        while ($urandom_range(0, 99) < gap_pct)
        begin
            in_ch.valid = 1'b0;
            @(negedge clk);
        end
        in_ch.valid    = 1'b1;
        in_ch.req_type = req;
        in_ch.in_byte  = c;
        do @(posedge clk); while (!in_ch.ready);
        sb.note_item(req, c);
    endtask

    task automatic send_text(string s);
        for (int i = 0; i < s.len(); i++)
            send_item(REQ_TEXT, s[i]);
    endtask

    // idle the input, wait for all events and for items that make none
    task automatic settle();
        @(negedge clk);
        in_ch.valid = 1'b0;
        while (sb.pending_events.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYC) @(posedge clk);
    endtask

    task automatic write_limit(logic [6:0] v);
        @(negedge clk);
        cfg_wr_en   = 1'b1;
        cfg_wr_data = v;
        @(negedge clk);
        cfg_wr_en   = 1'b0;
        sb.write_limit(v);
    endtask

    function automatic void push_item(logic [1:0] req, logic [7:0] c);
        stim_t s;
        s.req = req;
        s.ch  = c;
        line_q.push_back(s);
    endfunction

    // char of an unquoted token: never a delimiter, no quote in front
    function automatic logic [7:0] rand_plain(bit first);
        logic [7:0] c;
        if ($urandom_range(0, 3) != 0)
            return word_chars[$urandom_range(0, word_chars.len() - 1)];
        do
            c = 8'($urandom);
        while (c == CH_SPACE || c == CH_TAB || c == CH_LF || c == CH_CR || c == CH_HASH ||
               c == CH_EQ || (first && c == CH_QUOTE));
        return c;
    endfunction

    // char inside quotes: anything but the quote, with the odd ones favored
    function automatic logic [7:0] rand_quoted();
        logic [7:0] c;
        case ($urandom_range(0, 7))
            0:
            begin
                case ($urandom_range(0, 5))
                    0: c = CH_TAB;
                    1: c = CH_LF;
                    2: c = CH_CR;
                    3: c = CH_EQ;
                    4: c = CH_HASH;
                    default: c = CH_SPACE;
                endcase
            end
            1:
            begin
                do
                    c = 8'($urandom);
                while (c == CH_QUOTE);
            end
            default: c = word_chars[$urandom_range(0, word_chars.len() - 1)];
        endcase
        return c;
    endfunction

    // token length: mostly short, sometimes at or just past the limit
    function automatic int pick_len(bit allow_zero);
        int eff;
        int r;
        eff = sb.effective_limit();
        r   = $urandom_range(0, 15);
        if (r == 0)
            return eff + 1;
        if (r == 1)
            return eff;
        if (allow_zero && r == 2)
            return 0;
        return $urandom_range(1, (eff < 6) ? eff : 6);
    endfunction

    function automatic void add_blanks(int most);
        int n;
        n = $urandom_range(0, most);
        repeat (n) push_item(REQ_TEXT, ($urandom_range(0, 1) != 0) ? CH_SPACE : CH_TAB);
    endfunction

    function automatic void add_comment();
        int         n;
        logic [7:0] c;
        push_item(REQ_TEXT, CH_HASH);
        n = $urandom_range(0, 5);
        repeat (n)
        begin
            do
                c = 8'($urandom);
            while (c == CH_LF || c == CH_CR);
            push_item(REQ_TEXT, c);
        end
        push_item(REQ_TEXT, ($urandom_range(0, 1) != 0) ? CH_LF : CH_CR);
    endfunction

    function automatic void add_token();
        int n;
        if ($urandom_range(0, 3) == 0)
        begin
            push_item(REQ_TEXT, CH_QUOTE);
            if ($urandom_range(0, 9) == 0)
                push_item(REQ_TEXT, CH_EQ);
            else
            begin
                n = pick_len(1'b1);
                repeat (n) push_item(REQ_TEXT, rand_quoted());
            end
            push_item(REQ_TEXT, CH_QUOTE);
        end
        else
        begin
            n = pick_len(1'b0);
            push_item(REQ_TEXT, rand_plain(1'b1));
            repeat (n - 1) push_item(REQ_TEXT, rand_plain(1'b0));
        end
    endfunction

    // blanks between tokens, now and then a comment or a line break
    function automatic void add_gap();
        add_blanks(2);
        case ($urandom_range(0, 15))
            0, 1: add_comment();
            2:    push_item(REQ_TEXT, CH_LF);
            3:    push_item(REQ_TEXT, CH_CR);
            default: ;
        endcase
    endfunction

    // one line: mostly well formed pairs, some blank, comment, broken or noise
    function automatic void build_line();
        int kind;
        int n;
        int cut;
        line_q.delete();
        kind = $urandom_range(0, 19);
        if (kind == 0)
        begin
            add_blanks(2);
            push_item(REQ_TEXT, CH_LF);
        end
        else if (kind == 1)
        begin
            add_blanks(1);
            add_comment();
        end
        else if (kind == 2)
        begin
            n = $urandom_range(1, 4);
            repeat (n)
            begin
                if ($urandom_range(0, 7) < 5)
                    push_item(REQ_TEXT, 8'($urandom));
                else
                    push_item(2'($urandom_range(1, 3)), 8'($urandom));
            end
        end
        else
        begin
            add_blanks(2);
            add_token();
            add_gap();
            case ($urandom_range(0, 9))
                0:
                begin
                    push_item(REQ_TEXT, CH_QUOTE);
                    push_item(REQ_TEXT, CH_EQ);
                    push_item(REQ_TEXT, CH_QUOTE);
                end
                1: add_token();
                default: push_item(REQ_TEXT, CH_EQ);
            endcase
            add_gap();
            add_token();
            case ($urandom_range(0, 7))
                0:
                begin
                    push_item(REQ_TEXT, CH_CR);
                    push_item(REQ_TEXT, CH_LF);
                end
                1:
                begin
                    add_blanks(2);
                    add_comment();
                end
                2: push_item(REQ_END, 8'($urandom));
                3: push_item(REQ_TEXT, CH_EQ);
                default: push_item(REQ_TEXT, CH_LF);
            endcase
            // truncated line ended by end of input
            if (kind == 3)
            begin
                cut = $urandom_range(0, line_q.size() - 1);
                while (line_q.size() > cut)
                    void'(line_q.pop_back());
                push_item(REQ_END, 8'($urandom));
            end
            // one byte corrupted
            if (kind == 4)
                line_q[$urandom_range(0, line_q.size() - 1)].ch = 8'($urandom);
        end
    endfunction

    // send a line; once halted, usually drop the rest of it
    task automatic play_line();
        foreach (line_q[i])
        begin
            if (sb.phase == PH_HALTED && $urandom_range(0, 3) != 0)
                break;
            send_item(line_q[i].req, line_q[i].ch);
        end
    endtask

    task automatic run_block(int target);
        int start;
        start = sb.parsed_items;
        while (sb.parsed_items - start < target)
        begin
            if (sb.phase == PH_HALTED)
            begin
                if ($urandom_range(0, 3) == 0)
                    send_item(($urandom_range(0, 1) != 0) ? REQ_TEXT : REQ_END, 8'($urandom));
                send_item(REQ_RESTART, 8'($urandom));
            end
            else if ($urandom_range(0, 99) == 0)
                send_item(REQ_RESTART, 8'($urandom));
            else if ($urandom_range(0, 99) == 0)
                send_item(REQ_UNUSED, 8'($urandom));
            else
            begin
                build_line();
                play_line();
            end
        end
    endtask

    // main sequence
    initial
    begin
        logic [6:0] limits[8];
        sb             = new();
        clk            = 1'b0;
        rst_n          = 1'b0;
        cfg_wr_en      = 1'b0;
        cfg_wr_data    = '0;
        in_ch.valid    = 1'b0;
        in_ch.req_type = REQ_TEXT;
        in_ch.in_byte  = 8'h00;
        out_ch.ready   = 1'b0;
        gap_pct        = 0;
        stall_pct      = 0;
        cycle_count    = 0;

        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed: pairs, line breaks, comment, extreme bytes, quoted warnings
        send_text("k=v");
        send_item(REQ_TEXT, CH_CR);
        send_text("\n#c\n");
        send_item(REQ_TEXT, 8'hFF);
        send_item(REQ_TEXT, 8'h00);
        send_text("=\"\t=\"");
        // value ended by '=', then ignored and restart requests
        send_text("x=y=");
        send_item(REQ_UNUSED, 8'hA5);
        send_item(REQ_RESTART, 8'h5A);
        // end of input inside a quote
        send_text("\"ab");
        send_item(REQ_END, 8'h00);
        send_item(REQ_RESTART, 8'h00);

        // random: four idle patterns, two limit settings each
        limits = '{7'd64, 7'd1, 7'd0, 7'd127, 7'($urandom_range(2, 12)), 7'd64,
                   7'($urandom_range(0, 127)), 7'd5};
        for (int p = 0; p < 4; p++)
        begin
            case (p)
                0: begin gap_pct = 0;  stall_pct = 0;  end
                1: begin gap_pct = 58; stall_pct = 0;  end
                2: begin gap_pct = 0;  stall_pct = 58; end
                default: begin gap_pct = 31; stall_pct = 31; end
            endcase
            for (int s = 0; s < 2; s++)
            begin
                settle();
                write_limit(limits[p * 2 + s]);
                run_block(BLOCK_ITEMS);
            end
        end

        settle();
        if (sb.bad_events == 0)
            $display("key_value_config_lexer test passed");
        else
            $display("key_value_config_lexer test failed");
        $finish;
    end

endmodule
